>>> hw/rtl/wmbs_pkg.sv
// Shared types and constants for the weighted multi-dimensional best split block.
// Used by every module under hw/rtl; has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package wmbs_pkg;

  // Sizing
  localparam int MAX_SAMPLES = 1024;
  localparam int SAMP_W      = 10;   // sample slot address
  localparam int CNT_W       = 11;   // sample count, holds MAX_SAMPLES itself
  localparam int MAX_DIMS    = 8;
  localparam int DIM_W       = 3;    // coordinate index
  localparam int ADDR_W      = SAMP_W + DIM_W;
  localparam int CFG_W       = 4;
  localparam int VAL_W       = 12;
  localparam int WGT_W       = 8;
  localparam int TW_W        = 18;   // weight totals
  localparam int SQ_W        = 44;   // weighted sum of squares
  localparam int SUM_W       = 32;   // per-dimension weighted sums
  localparam int MOP_W       = 34;   // multiplier operand
  localparam int ACC_W       = 64;   // squared norms, quotients, costs
  localparam int BASE_W      = 20;
  localparam int IDX_W       = 21;
  localparam int STAT_W      = 2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZDIV = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DROP = 2'd2;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_MUL,
    S_LD_ACC,
    S_R0_MUL,
    S_R0_ACC,
    S_BQ_START,
    S_BQ_WAIT,
    S_BQ_DONE,
    S_SC_RDW,
    S_SC_WT,
    S_SC_RDV,
    S_SC_MWV,
    S_SC_ADDL,
    S_SC_ML,
    S_SC_MR,
    S_SC_AR,
    S_SC_LSTART,
    S_SC_LWAIT,
    S_SC_RSTART,
    S_SC_RWAIT,
    S_SC_CMP,
    S_FINISH
  } state_t;

  // Write side of the sample store
  typedef struct packed {
    logic                     val_we;
    logic                     wgt_we;
    logic [SAMP_W-1:0]        samp;
    logic [DIM_W-1:0]         coord;
    logic signed [VAL_W-1:0]  value;
    logic [WGT_W-1:0]         weight;
    logic [DIM_W-1:0]         ncoord;  // highest coordinate written in the sample
  } store_wr_t;

endpackage

`default_nettype wire

>>> hw/rtl/wmbs_store.sv
// Sample store: coordinate values, sample weights and per-sample coordinate extent.
// Depends on wmbs_pkg. One write and one registered read per memory each cycle.
`timescale 1ns / 1ps
`default_nettype none

module wmbs_store
  import wmbs_pkg::*;
(
  input  wire logic                    clk,
  input  wire store_wr_t               wr,
  input  wire logic [SAMP_W-1:0]       rd_samp,
  input  wire logic [DIM_W-1:0]        rd_coord,
  output logic signed [VAL_W-1:0]      rd_value,
  output logic [WGT_W-1:0]             rd_weight,
  output logic [DIM_W-1:0]             rd_ncoord
);

  logic signed [VAL_W-1:0] value_mem  [2**ADDR_W];
  logic [WGT_W-1:0]        weight_mem [2**SAMP_W];
  logic [DIM_W-1:0]        ncoord_mem [2**SAMP_W];

  // Value memory
  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      value_mem[{wr.samp, wr.coord}] <= wr.value;
    end
    rd_value <= value_mem[{rd_samp, rd_coord}];
  end

  // Weight memory, written on a sample's first coordinate
  always_ff @(posedge clk) begin
    if (wr.wgt_we) begin
      weight_mem[wr.samp] <= wr.weight;
    end
    rd_weight <= weight_mem[rd_samp];
  end

  // Coordinate extent, updated on every stored coordinate
  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      ncoord_mem[wr.samp] <= wr.ncoord;
    end
    rd_ncoord <= ncoord_mem[rd_samp];
  end

endmodule

`default_nettype wire

>>> hw/rtl/wmbs_mul.sv
// Shared signed multiplier with a registered product.
// Depends on wmbs_pkg for operand and result widths.
`timescale 1ns / 1ps
`default_nettype none

module wmbs_mul
  import wmbs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic signed [MOP_W-1:0] a,
  input  wire logic signed [MOP_W-1:0] b,
  output logic [ACC_W-1:0]             prod
);

  logic signed [2*MOP_W-1:0] full;

  // Low 64 bits are the wrapped square or product
  assign full = a * b;

  always_ff @(posedge clk) begin
    prod <= full[ACC_W-1:0];
  end

endmodule

`default_nettype wire

>>> hw/rtl/wmbs_div.sv
// Restoring divider: 64-bit unsigned numerator by 18-bit nonzero divisor, one bit a cycle.
// Depends on wmbs_pkg. Quotient valid when done pulses.
`timescale 1ns / 1ps
`default_nettype none

module wmbs_div
  import wmbs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [ACC_W-1:0] num,
  input  wire logic [TW_W-1:0]  den,
  output logic                  done,
  output logic [ACC_W-1:0]      quot
);

  localparam int CW = $clog2(ACC_W);

  logic            busy;
  logic [CW-1:0]   cnt;
  logic [ACC_W-1:0] qr;     // numerator shifts out, quotient shifts in
  logic [TW_W-1:0] rem;
  logic [TW_W-1:0] den_r;
  logic [TW_W:0]   trial;
  logic [TW_W:0]   diff;
  logic            ge;

  assign trial = {rem, qr[ACC_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign quot  = qr;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(ACC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      qr    <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[TW_W-1:0] : trial[TW_W-1:0];
      qr  <= {qr[ACC_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/weighted_multidim_best_split.sv
// Best single split of a weighted multi-dimensional segment. Coordinates arrive one per
// transfer and each is loaded through S_LD_MUL and S_LD_ACC (a shared multiplier forms
// w*v, then w*v*v). The transfer marked last_sample starts the scan, during which input
// is stalled: the whole-segment term (8 squares, one divide and the S_BQ_DONE setup
// state), then for each of the n-1 split points the reads and multiplies (8 dimensions,
// 3 products each, through the single multiplier) plus two divides through the single
// bit-serial divider and one compare. A divide is skipped where its divisor weight is
// zero. The result sits in an output register, so the next segment may load while it
// waits to be taken. Depends on wmbs_pkg, wmbs_store, wmbs_mul and wmbs_div.
`timescale 1ns / 1ps
`default_nettype none

module weighted_multidim_best_split
  import wmbs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_W-1:0]        cfg_data,
  // input items
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [BASE_W-1:0]       base_index,
  input  wire logic [WGT_W-1:0]        sample_weight,
  input  wire logic signed [VAL_W-1:0] sample_value,
  input  wire logic                    last_sample,
  // results
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [IDX_W-1:0]             split_index,
  output logic signed [ACC_W-1:0]      split_cost,
  output logic [STAT_W-1:0]            status
);

  state_t state, state_next;

  logic [CFG_W-1:0]        dims_cfg;
  logic [CNT_W-1:0]        sample_count;
  logic [DIM_W-1:0]        coord_count;
  logic [DIM_W-1:0]        cur_max;
  logic [WGT_W-1:0]        cur_w;
  logic [TW_W-1:0]         total_weight;
  logic [TW_W-1:0]         left_weight;
  logic [SQ_W-1:0]         square_sum;
  logic                    drop_seen;
  logic [BASE_W-1:0]       segment_base;
  logic signed [SUM_W-1:0] right_sums [MAX_DIMS];
  logic signed [SUM_W-1:0] left_sums  [MAX_DIMS];

  // latched item for the load states
  logic signed [VAL_W-1:0] lv;
  logic [DIM_W-1:0]        lc;
  logic                    lat_last;
  logic                    lat_store;

  // scan registers
  logic [DIM_W-1:0]        d;
  logic [CNT_W-1:0]        i;
  logic [WGT_W-1:0]        w_reg;
  logic [DIM_W-1:0]        nc_reg;
  logic [ACC_W-1:0]        acc_a;
  logic [ACC_W-1:0]        acc_b;
  logic [ACC_W-1:0]        base_q;
  logic [ACC_W-1:0]        ql;
  logic [ACC_W-1:0]        qr;
  logic [ACC_W-1:0]        best_cost;
  logic [CNT_W-1:0]        best_index;
  logic                    zero_div;

  // shared units
  logic signed [MOP_W-1:0] mul_a, mul_b;
  logic [ACC_W-1:0]        prod;
  logic                    div_start, div_done;
  logic [ACC_W-1:0]        div_num, div_quot;
  logic [TW_W-1:0]         div_den;
  store_wr_t               st_wr;
  logic [SAMP_W-1:0]       rd_samp;
  logic signed [VAL_W-1:0] rd_value;
  logic [WGT_W-1:0]        rd_weight;
  logic [DIM_W-1:0]        rd_ncoord;

  // derived
  logic                    in_take;
  logic                    out_free;
  logic [CFG_W-1:0]        dims_eff;
  logic [CFG_W-1:0]        dims_m1_w;
  logic [DIM_W-1:0]        dm1;
  logic [DIM_W-1:0]        c_eff;
  logic                    storing;
  logic                    end_samp;
  logic [WGT_W-1:0]        w_eff;
  logic [DIM_W-1:0]        nc_new;
  logic [DIM_W-1:0]        sum_idx;
  logic signed [SUM_W-1:0] right_rd;
  logic signed [SUM_W-1:0] left_rd;
  logic [CNT_W-1:0]        i_m1;
  logic [CNT_W-1:0]        i_p1;
  logic [TW_W-1:0]         right_w;
  logic [ACC_W-1:0]        cost;

  assign cfg_ready = 1'b1;

  // Handshake
  assign in_stall = !(state == S_IDLE || (state == S_LD_ACC && !lat_last));
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Coordinate bookkeeping for the item being taken
  assign dims_eff  = (dims_cfg == '0) ? CFG_W'(1) :
                     (dims_cfg > CFG_W'(MAX_DIMS)) ? CFG_W'(MAX_DIMS) : dims_cfg;
  assign dims_m1_w = dims_eff - CFG_W'(1);
  assign dm1       = dims_m1_w[DIM_W-1:0];
  assign c_eff     = (coord_count > dm1) ? dm1 : coord_count;
  assign storing   = sample_count < CNT_W'(MAX_SAMPLES);
  assign end_samp  = (c_eff == dm1) || last_sample;
  assign w_eff     = (c_eff == '0) ? sample_weight : cur_w;
  assign nc_new    = (c_eff == '0) ? '0 : ((cur_max > c_eff) ? cur_max : c_eff);

  always_comb begin
    st_wr.val_we = in_take && storing;
    st_wr.wgt_we = in_take && storing && (c_eff == '0);
    st_wr.samp   = sample_count[SAMP_W-1:0];
    st_wr.coord  = c_eff;
    st_wr.value  = sample_value;
    st_wr.weight = sample_weight;
    st_wr.ncoord = nc_new;
  end

  // Sum register read port
  assign sum_idx  = (state == S_LD_MUL) ? lc : d;
  assign right_rd = right_sums[sum_idx];
  assign left_rd  = left_sums[d];

  assign i_m1    = i - CNT_W'(1);
  assign i_p1    = i + CNT_W'(1);
  assign rd_samp = i_m1[SAMP_W-1:0];
  assign right_w = total_weight - left_weight;
  assign cost    = base_q - ql - qr;

  wmbs_store u_store (
    .clk       (clk),
    .wr        (st_wr),
    .rd_samp   (rd_samp),
    .rd_coord  (d),
    .rd_value  (rd_value),
    .rd_weight (rd_weight),
    .rd_ncoord (rd_ncoord)
  );

  wmbs_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  wmbs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_take) state_next = S_LD_MUL;
      S_LD_MUL:    state_next = S_LD_ACC;
      S_LD_ACC: begin
        if (lat_last)     state_next = S_R0_MUL;
        else if (in_take) state_next = S_LD_MUL;
        else              state_next = S_IDLE;
      end
      S_R0_MUL:    state_next = S_R0_ACC;
      S_R0_ACC:    state_next = (d == DIM_W'(MAX_DIMS - 1)) ? S_BQ_START : S_R0_MUL;
      S_BQ_START:  state_next = (total_weight == '0) ? S_BQ_DONE : S_BQ_WAIT;
      S_BQ_WAIT:   if (div_done) state_next = S_BQ_DONE;
      S_BQ_DONE:   state_next = (sample_count > CNT_W'(1)) ? S_SC_RDW : S_FINISH;
      S_SC_RDW:    state_next = S_SC_WT;
      S_SC_WT:     state_next = S_SC_RDV;
      S_SC_RDV:    state_next = S_SC_MWV;
      S_SC_MWV:    state_next = S_SC_ADDL;
      S_SC_ADDL:   state_next = S_SC_ML;
      S_SC_ML:     state_next = S_SC_MR;
      S_SC_MR:     state_next = S_SC_AR;
      S_SC_AR:     state_next = (d == DIM_W'(MAX_DIMS - 1)) ? S_SC_LSTART : S_SC_RDV;
      S_SC_LSTART: state_next = (left_weight == '0) ? S_SC_RSTART : S_SC_LWAIT;
      S_SC_LWAIT:  if (div_done) state_next = S_SC_RSTART;
      S_SC_RSTART: state_next = (right_w == '0) ? S_SC_CMP : S_SC_RWAIT;
      S_SC_RWAIT:  if (div_done) state_next = S_SC_CMP;
      S_SC_CMP:    state_next = (i_p1 < sample_count) ? S_SC_RDW : S_FINISH;
      S_FINISH:    if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Shared unit controls
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = acc_a;
    div_den   = total_weight;
    case (state)
      S_IDLE, S_LD_ACC: begin
        mul_a = MOP_W'(w_eff);
        mul_b = {{(MOP_W-VAL_W){sample_value[VAL_W-1]}}, sample_value};
      end
      S_LD_MUL: begin
        mul_a = prod[MOP_W-1:0];
        mul_b = {{(MOP_W-VAL_W){lv[VAL_W-1]}}, lv};
      end
      S_R0_MUL: begin
        mul_a = {{(MOP_W-SUM_W){right_rd[SUM_W-1]}}, right_rd};
        mul_b = {{(MOP_W-SUM_W){right_rd[SUM_W-1]}}, right_rd};
      end
      S_SC_MWV: begin
        mul_a = MOP_W'(w_reg);
        mul_b = (d <= nc_reg) ? {{(MOP_W-VAL_W){rd_value[VAL_W-1]}}, rd_value} : '0;
      end
      S_SC_ML: begin
        mul_a = {{(MOP_W-SUM_W){left_rd[SUM_W-1]}}, left_rd};
        mul_b = {{(MOP_W-SUM_W){left_rd[SUM_W-1]}}, left_rd};
      end
      S_SC_MR: begin
        mul_a = {{(MOP_W-SUM_W){right_rd[SUM_W-1]}}, right_rd}
              - {{(MOP_W-SUM_W){left_rd[SUM_W-1]}}, left_rd};
        mul_b = mul_a;
      end
      S_BQ_START: begin
        div_start = (total_weight != '0);
      end
      S_SC_LSTART: begin
        div_start = (left_weight != '0);
        div_den   = left_weight;
      end
      S_SC_RSTART: begin
        div_start = (right_w != '0);
        div_num   = acc_b;
        div_den   = right_w;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_cfg <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      dims_cfg <= cfg_data;
    end
  end

  // Segment state, loading and scan datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      coord_count  <= '0;
      cur_max      <= '0;
      total_weight <= '0;
      left_weight  <= '0;
      square_sum   <= '0;
      drop_seen    <= 1'b0;
      segment_base <= '0;
      lat_last     <= 1'b0;
      lat_store    <= 1'b0;
      zero_div     <= 1'b0;
      best_cost    <= '0;
      best_index   <= '0;
      out_valid    <= 1'b0;
      for (int k = 0; k < MAX_DIMS; k++) begin
        right_sums[k] <= '0;
        left_sums[k]  <= '0;
      end
    end else begin
      // result transfer; a new result loads in the finish state instead
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      // item transfer
      if (in_take) begin
        if (sample_count == '0 && coord_count == '0) begin
          segment_base <= base_index;
        end
        if (storing) begin
          cur_max <= nc_new;
          if (c_eff == '0) begin
            cur_w        <= sample_weight;
            total_weight <= total_weight + TW_W'(sample_weight);
          end
        end else begin
          drop_seen <= 1'b1;
        end
        if (end_samp) begin
          coord_count <= '0;
          if (storing) begin
            sample_count <= sample_count + CNT_W'(1);
          end
        end else begin
          coord_count <= c_eff + DIM_W'(1);
        end
        lv        <= sample_value;
        lc        <= c_eff;
        lat_last  <= last_sample;
        lat_store <= storing;
      end

      case (state)
        S_LD_MUL: begin
          if (lat_store) right_sums[lc] <= right_rd + prod[SUM_W-1:0];
        end
        S_LD_ACC: begin
          if (lat_store) square_sum <= square_sum + prod[SQ_W-1:0];
          if (lat_last) begin
            d        <= '0;
            acc_a    <= '0;
            zero_div <= 1'b0;
          end
        end
        S_R0_ACC: begin
          acc_a <= acc_a + prod;
          d     <= d + DIM_W'(1);
        end
        S_BQ_START: begin
          if (total_weight == '0) begin
            base_q   <= '0;
            zero_div <= 1'b1;
          end
        end
        S_BQ_WAIT: begin
          if (div_done) base_q <= div_quot;
        end
        S_BQ_DONE: begin
          best_cost   <= ACC_W'(square_sum) - base_q + ACC_W'(1);
          best_index  <= '0;
          left_weight <= '0;
          i           <= CNT_W'(1);
        end
        S_SC_WT: begin
          w_reg       <= rd_weight;
          nc_reg      <= rd_ncoord;
          left_weight <= left_weight + TW_W'(rd_weight);
          d           <= '0;
          acc_a       <= '0;
          acc_b       <= '0;
        end
        S_SC_ADDL: begin
          left_sums[d] <= left_rd + prod[SUM_W-1:0];
        end
        S_SC_MR: begin
          acc_a <= acc_a + prod;
        end
        S_SC_AR: begin
          acc_b <= acc_b + prod;
          d     <= d + DIM_W'(1);
        end
        S_SC_LSTART: begin
          if (left_weight == '0) begin
            ql       <= '0;
            zero_div <= 1'b1;
          end
        end
        S_SC_LWAIT: begin
          if (div_done) ql <= div_quot;
        end
        S_SC_RSTART: begin
          if (right_w == '0) begin
            qr       <= '0;
            zero_div <= 1'b1;
          end
        end
        S_SC_RWAIT: begin
          if (div_done) qr <= div_quot;
        end
        S_SC_CMP: begin
          if ($signed(cost) < $signed(best_cost)) begin
            best_cost  <= cost;
            best_index <= i;
          end
          i <= i_p1;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            split_index  <= IDX_W'(segment_base) + IDX_W'(best_index);
            split_cost   <= best_cost;
            status       <= drop_seen ? STAT_DROP : (zero_div ? STAT_ZDIV : STAT_OK);
            // clear the segment
            square_sum   <= '0;
            total_weight <= '0;
            left_weight  <= '0;
            sample_count <= '0;
            coord_count  <= '0;
            cur_max      <= '0;
            drop_seen    <= 1'b0;
            for (int k = 0; k < MAX_DIMS; k++) begin
              right_sums[k] <= '0;
              left_sums[k]  <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Items are only taken in the load states
  a_take_state: assert property (@(posedge clk) disable iff (rst)
    in_take |-> (state == S_IDLE || state == S_LD_ACC))
    else $error("item taken outside load states");

  // Held sample count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  // Emitting a result clears the segment and returns to loading
  a_finish_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> (sample_count == '0 && state == S_IDLE && out_valid))
    else $error("segment not cleared after result");

endmodule

`default_nettype wire

>>> tb/wmbs_checker.sv
// Scoreboard for weighted_multidim_best_split: watches the config, input and result channels,
// predicts each segment's best split and compares it with what the block returns.
// Depends on wmbs_pkg for widths and status codes.
`timescale 1ns / 1ps

module wmbs_checker
  import wmbs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [BASE_W-1:0]       base_index,
  input  logic [WGT_W-1:0]        sample_weight,
  input  logic signed [VAL_W-1:0] sample_value,
  input  logic                    last_sample,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [IDX_W-1:0]        split_index,
  input  logic signed [ACC_W-1:0] split_cost,
  input  logic [STAT_W-1:0]       status,
  output int                      fail_count,
  output int                      splits_pending,
  output int                      splits_seen
);

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [ACC_W-1:0] cost;
    logic [STAT_W-1:0]       stat;
  } split_t;

  split_t split_q[$];

  // predictor state
  logic [CFG_W-1:0]  dims_cfg;
  longint            coord_mem[MAX_SAMPLES][MAX_DIMS];
  longint            wgt_mem[MAX_SAMPLES];
  logic [63:0]       sq_acc;
  longint            rsum[MAX_DIMS];
  longint            lsum[MAX_DIMS];
  logic [31:0]       wtot;
  logic [31:0]       wleft;
  int unsigned       nsamp;
  int unsigned       ncoord;
  logic [BASE_W-1:0] seg_base;
  bit                dropped;

  function automatic logic [63:0] mag_sq(longint s);
    logic [63:0] m;
    m = s[63] ? 64'(-s) : 64'(s);
    return m * m;
  endfunction

  function automatic logic [63:0] trunc_div(logic [63:0] a, logic [31:0] b, ref bit zdiv);
    if (b == 0) begin
      zdiv = 1;
      return 0;
    end
    return a / 64'(b);
  endfunction

  task automatic clear_seg();
    sq_acc = 0;
    wtot = 0;
    wleft = 0;
    nsamp = 0;
    ncoord = 0;
    dropped = 0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      rsum[d] = 0;
      lsum[d] = 0;
    end
  endtask

  // scan all split points of the held segment and queue the winner
  task automatic scan_segment();
    logic [63:0] r0, base_q, l2, r2, cost;
    longint      best_c, w;
    int unsigned best_i;
    bit          zdiv;
    split_t      e;
    zdiv = 0;
    r0 = 0;
    for (int d = 0; d < MAX_DIMS; d++) r0 += mag_sq(rsum[d]);
    base_q = trunc_div(r0, wtot, zdiv);
    best_c = longint'(sq_acc - base_q + 64'd1);
    best_i = 0;
    wleft = 0;
    for (int unsigned i = 1; i < nsamp; i++) begin
      w = wgt_mem[i-1];
      wleft += 32'(w);
      l2 = 0;
      r2 = 0;
      for (int d = 0; d < MAX_DIMS; d++) begin
        lsum[d] += w * coord_mem[i-1][d];
        l2 += mag_sq(lsum[d]);
        r2 += mag_sq(rsum[d] - lsum[d]);
      end
      cost = base_q - trunc_div(l2, wleft, zdiv) - trunc_div(r2, wtot - wleft, zdiv);
      if (longint'(cost) < best_c) begin
        best_c = longint'(cost);
        best_i = i;
      end
    end
    e.idx  = IDX_W'(32'(seg_base) + best_i);
    e.cost = best_c;
    e.stat = dropped ? STAT_DROP : (zdiv ? STAT_ZDIV : STAT_OK);
    split_q.insert(split_q.size(), e);
    clear_seg();
  endtask

  // fold one coordinate into the segment
  task automatic load_coord();
    int unsigned dims, c;
    longint      v, w;
    bit          keep;
    dims = (dims_cfg == 0) ? 1 : (dims_cfg > MAX_DIMS) ? MAX_DIMS : dims_cfg;
    v = longint'(sample_value);
    if (nsamp == 0 && ncoord == 0) seg_base = base_index;
    c = (ncoord > dims - 1) ? dims - 1 : ncoord;
    keep = nsamp < MAX_SAMPLES;
    if (keep) begin
      if (c == 0) begin
        for (int d = 0; d < MAX_DIMS; d++) coord_mem[nsamp][d] = 0;
        wgt_mem[nsamp] = longint'(sample_weight);
        wtot += 32'(sample_weight);
      end
      w = wgt_mem[nsamp];
      coord_mem[nsamp][c] = v;
      sq_acc += 64'(w * v * v);
      rsum[c] += w * v;
    end else begin
      dropped = 1;
    end
    if (c + 1 >= dims || last_sample) begin
      ncoord = 0;
      if (keep) nsamp++;
    end else begin
      ncoord = c + 1;
    end
    if (last_sample) scan_segment();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dims_cfg <= 1;
      clear_seg();
      split_q.delete();
      fail_count <= 0;
      splits_seen <= 0;
    end else begin
      if (in_valid && !in_stall) load_coord();
      if (cfg_valid && cfg_ready) dims_cfg <= cfg_data;
      // result transfer
      if (out_valid && !out_stall) begin
        splits_seen <= splits_seen + 1;
        if (split_q.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: unexpected result, expected none, got idx=%0d cost=%0d status=%0d",
                   $time, split_index, split_cost, status);
        end else begin
          split_t e;
          e = split_q.pop_front();
          if (e.idx !== split_index || e.cost !== split_cost || e.stat !== status) begin
            fail_count <= fail_count + 1;
            $display("%0t: mismatch exp idx=%0d cost=%0d status=%0d,",
                     $time, e.idx, e.cost, e.stat);
            $display("    got idx=%0d cost=%0d status=%0d",
                     split_index, split_cost, status);
          end
        end
      end
    end
  end

  assign splits_pending = split_q.size();

endmodule

>>> tb/tb_weighted_multidim_best_split.sv
// Testbench top for weighted_multidim_best_split: clock, reset, stimulus and verdict.
// Depends on wmbs_pkg, the block itself and wmbs_checker.
`timescale 1ns / 1ps

module tb_weighted_multidim_best_split;
  import wmbs_pkg::*;

  localparam int ITEM_GOAL = 1700;
  localparam int CYCLE_CAP = 4000000;

  logic                    clk = 0;
  logic                    rst = 1;
  logic                    cfg_valid = 0;
  logic                    cfg_ready;
  logic [CFG_W-1:0]        cfg_data = 0;
  logic                    in_valid = 0;
  logic                    in_stall;
  logic [BASE_W-1:0]       base_index = 0;
  logic [WGT_W-1:0]        sample_weight = 0;
  logic signed [VAL_W-1:0] sample_value = 0;
  logic                    last_sample = 0;
  logic                    out_valid;
  logic                    out_stall = 0;
  logic [IDX_W-1:0]        split_index;
  logic signed [ACC_W-1:0] split_cost;
  logic [STAT_W-1:0]       status;
  int                      fail_count, splits_pending, splits_seen;
  int                      items_sent = 0, segs_sent = 0, cfg_writes = 0, burst_left = 0;
  int                      cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  weighted_multidim_best_split dut (.*);

  wmbs_checker chk (.*);

  // receiver stall pattern changes character as cycles[10:9] steps through its values
  always @(posedge clk) begin
    cycles <= cycles + 1;
    case (cycles[10:9])
      2'd0: out_stall <= 0;
      2'd1: out_stall <= $urandom_range(0, 1);
      2'd2: out_stall <= ($urandom_range(0, 9) != 0);
      default: out_stall <= ($urandom_range(0, 7) == 0);
    endcase
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one input transfer; the sender runs in bursts with random gaps
  task automatic send(logic [BASE_W-1:0] b, logic [WGT_W-1:0] w,
                      logic signed [VAL_W-1:0] v, logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid      <= 1;
    base_index    <= b;
    sample_weight <= w;
    sample_value  <= v;
    last_sample   <= l;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  // wait for all results plus load drain, then write the dimension register
  task automatic write_dims(logic [CFG_W-1:0] val);
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (splits_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 0;
    cfg_writes++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return -12'sd2048;
      1: return 12'sd2047;
      2: return 12'(signed'($urandom_range(0, 6)) - 3);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [WGT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 8'd255;
      default: return WGT_W'($urandom);
    endcase
  endfunction

  // a segment of nsmp samples at dimension count dims, sometimes cut short
  task automatic send_segment(int nsmp, int dims, bit cut);
    logic [BASE_W-1:0] b;
    logic [WGT_W-1:0]  w;
    int                stop;
    b = ($urandom_range(0, 9) == 0) ? '1 : BASE_W'($urandom);
    for (int s = 0; s < nsmp; s++) begin
      w = pick_weight();
      stop = (cut && s == nsmp - 1) ? $urandom_range(1, dims) : dims;
      for (int c = 0; c < stop; c++)
        send(b, w, pick_value(), s == nsmp - 1 && c == stop - 1);
    end
    segs_sent++;
  endtask

  initial begin
    int dims;
    bit drop_done;
    drop_done = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // single sample at the top base index with extreme value and weight
    send('1, 8'd255, -12'sd2048, 1);
    // zero first weight gives a zero left-weight divisor
    send(20'd0, 8'd0, 12'sd2047, 0);
    send(20'd0, 8'd255, -12'sd2048, 0);
    send(20'd0, 8'd1, 12'sd0, 1);
    // register value zero behaves as one dimension
    write_dims(4'd0);
    send(20'd5, 8'd0, 12'sd7, 0);
    send(20'd5, 8'd0, -12'sd7, 1);
    // register above the maximum behaves as eight dimensions
    write_dims(4'd15);
    for (int c = 0; c < 8; c++)
      send(20'hAAAAA, 8'd255, c[0] ? 12'sd2047 : -12'sd2048, c == 7);
    // early end of a sample
    write_dims(4'd3);
    send(20'h55555, 8'd3, 12'sd100, 0);
    send(20'h55555, 8'd3, -12'sd50, 0);
    send(20'h55555, 8'd3, 12'sd9, 0);
    send(20'h55555, 8'd4, -12'sd300, 1);
    // dimension count shrinks in the middle of a sample
    send(20'd77, 8'd9, 12'sd11, 0);
    send(20'd77, 8'd9, 12'sd22, 0);
    write_dims(4'd1);
    send(20'd77, 8'd6, -12'sd33, 1);
    write_dims(4'd8);
    send_segment(2, 8, 0);

    // random segments, mostly small; one oversized segment to overflow the store
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 5) == 0) begin
        dims = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 8);
        write_dims(CFG_W'(dims));
      end else if ($urandom_range(0, 9) == 0) begin
        in_valid <= 0;
        burst_left = 0;
        @(posedge clk);
        while (splits_pending != 0) @(posedge clk);
      end
      dims = (chk.dims_cfg == 0) ? 1 : (chk.dims_cfg > MAX_DIMS) ? MAX_DIMS : chk.dims_cfg;
      if (!drop_done && items_sent > 600) begin
        write_dims(4'd1);
        send_segment(MAX_SAMPLES + 3, 1, 0);
        drop_done = 1;
      end else begin
        send_segment($urandom_range(0, 19) == 0 ? $urandom_range(8, 24) : $urandom_range(1, 5),
                     dims, $urandom_range(0, 5) == 0);
      end
    end

    in_valid <= 0;
    @(posedge clk);
    while (splits_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d items in %0d segments, %0d register writes, %0d results checked",
             items_sent, segs_sent, cfg_writes, splits_seen);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
